// File: src/frtc_pkg.sv
package frtc_pkg;

    localparam int MaxSamples = 128;
    localparam int NumW       = 8;
    localparam int DividendW  = 31;
    localparam int DivisorW   = 20;
    localparam int DivCntW    = 5;

    typedef logic [8:0]      t_mu;
    typedef logic [2:0][8:0] t_mu3;

    localparam t_mu MuOne = 9'd256;

    // output axis in q4.12
    localparam logic [15:0] XSpan = 16'd61440;
    localparam logic [15:0] X4    = 16'd16384;
    localparam logic [15:0] X8    = 16'd32768;
    localparam logic [15:0] X12   = 16'd49152;
    localparam logic [11:0] RinseMax = 12'd3840;

    // reciprocals, 2^28 / run rounded up
    localparam logic [24:0] K16 = 25'((2**28 + 15) / 16);
    localparam logic [24:0] K48 = 25'((2**28 + 47) / 48);
    localparam logic [24:0] K65 = 25'((2**28 + 64) / 65);
    localparam logic [24:0] K70 = 25'((2**28 + 69) / 70);

    localparam logic [11:0] LwP0 = 12'd64,  LwP1 = 12'd80,  LwP2 = 12'd112, LwP3 = 12'd160;
    localparam logic [11:0] FdP0 = 12'd135, FdP1 = 12'd200, FdP2 = 12'd270, FdP3 = 12'd340;
    localparam logic [11:0] DaP0 = 12'd16,  DaP1 = 12'd32,  DaP2 = 12'd48,  DaP3 = 12'd64;

    typedef enum logic [1:0] {C_QUICK, C_MODERATE, C_LONG} t_cls;

    // class of rule 9*w + 3*f + d
    localparam t_cls RuleClass [27] = '{
        C_QUICK,    C_QUICK,    C_QUICK,    C_QUICK,    C_QUICK,    C_MODERATE,
        C_QUICK,    C_QUICK,    C_MODERATE, C_QUICK,    C_MODERATE, C_MODERATE,
        C_QUICK,    C_MODERATE, C_LONG,     C_MODERATE, C_LONG,     C_LONG,
        C_QUICK,    C_MODERATE, C_LONG,     C_MODERATE, C_LONG,     C_LONG,
        C_MODERATE, C_LONG,     C_LONG
    };

    typedef struct packed {
        logic load_in;
        logic div_start;
        logic div_final;
        logic init;
        logic advance;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic last_sample;
    } t_stat;

    function automatic t_mu scale(input logic [6:0] d, input logic [24:0] k);
        logic [31:0] p;
        p = {25'd0, d} * {7'd0, k};
        return p[28:20];
    endfunction

    function automatic t_mu3 fuzz(input logic [11:0] v,
                                  input logic [11:0] p0, input logic [11:0] p1,
                                  input logic [11:0] p2, input logic [11:0] p3,
                                  input logic [24:0] ka, input logic [24:0] kb);
        t_mu3        m;
        logic [11:0] d_p1v;
        logic [11:0] d_vp0;
        logic [11:0] d_p3v;
        logic [11:0] d_vp2;
        d_p1v = p1 - v;
        d_vp0 = v - p0;
        d_p3v = p3 - v;
        d_vp2 = v - p2;
        if (v <= p0) m[0] = MuOne;
        else if (v < p1) m[0] = scale(d_p1v[6:0], ka);
        else m[0] = '0;
        if (v <= p0 || v >= p3) m[1] = '0;
        else if (v < p1) m[1] = scale(d_vp0[6:0], ka);
        else if (v > p2) m[1] = scale(d_p3v[6:0], kb);
        else m[1] = MuOne;
        if (v >= p3) m[2] = MuOne;
        else if (v > p2) m[2] = scale(d_vp2[6:0], kb);
        else m[2] = '0;
        return m;
    endfunction

    function automatic t_mu min2(input t_mu a, input t_mu b);
        return (a < b) ? a : b;
    endfunction

    function automatic t_mu max2(input t_mu a, input t_mu b);
        return (a > b) ? a : b;
    endfunction

    function automatic t_mu out_mu(input logic [15:0] x, input t_mu3 cls);
        t_mu q;
        t_mu m;
        t_mu l;
        logic [15:0] t;
        if (x <= X4) q = MuOne;
        else if (x < X8) begin
            t = X8 - x;
            q = {1'b0, t[13:6]};
        end else q = '0;
        if (x == X8) m = MuOne;
        else if (x > X4 && x < X8) begin
            t = x - X4;
            m = {1'b0, t[13:6]};
        end else if (x > X8 && x < X12) begin
            t = X12 - x;
            m = {1'b0, t[13:6]};
        end else m = '0;
        if (x <= X8) l = '0;
        else if (x < X12) begin
            t = x - X8;
            l = {1'b0, t[13:6]};
        end else l = MuOne;
        return max2(min2(q, cls[0]), max2(min2(m, cls[1]), min2(l, cls[2])));
    endfunction

endpackage

// File: src/frtc_div.sv
module frtc_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [frtc_pkg::DividendW-1:0]   i_dividend,
    input  logic [frtc_pkg::DivisorW-1:0]    i_divisor,
    output logic                             o_busy,
    output logic [frtc_pkg::DividendW-1:0]   o_quotient,
    output logic [frtc_pkg::DivisorW-1:0]    o_remainder
);

    logic [frtc_pkg::DivCntW-1:0]    r_cnt;
    logic [frtc_pkg::DividendW-1:0]  r_quo;
    logic [frtc_pkg::DivisorW-1:0]   r_rem;
    logic [frtc_pkg::DivisorW-1:0]   r_dvs;
    logic [frtc_pkg::DivisorW:0]     trial;
    logic                            fits;

    assign trial = {r_rem, r_quo[frtc_pkg::DividendW-1]};
    assign fits  = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= frtc_pkg::DivCntW'(frtc_pkg::DividendW);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[frtc_pkg::DividendW-2:0], fits};
            r_rem <= fits ? frtc_pkg::DivisorW'(trial - {1'b0, r_dvs})
                          : trial[frtc_pkg::DivisorW-1:0];
        end
    end

    assign o_busy      = r_cnt != '0;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// File: src/frtc_datapath.sv
module frtc_datapath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  frtc_pkg::t_cmd            i_cmd,
    output frtc_pkg::t_stat           o_st,
    input  logic [31:0]               i_in_data,
    input  logic                      i_cfg_we,
    input  logic [frtc_pkg::NumW-1:0] i_cfg_wdata,
    output logic [11:0]               o_rinse_time,
    output logic                      o_no_rule_fired
);

    logic [frtc_pkg::NumW-1:0]     r_num;
    logic [frtc_pkg::NumW-1:0]     n_eff;
    logic [11:0]                   r_load;
    logic [9:0]                    r_dens;
    logic [7:0]                    r_det;
    frtc_pkg::t_mu3                r_mw, r_mf, r_md;
    frtc_pkg::t_mu                 n_part [3][3];
    frtc_pkg::t_mu                 r_part [3][3];
    frtc_pkg::t_mu3                r_cls;
    logic [frtc_pkg::NumW-1:0]     r_cnt;
    logic [15:0]                   r_x;
    logic [7:0]                    r_xr;
    logic                          r_xv;
    logic [15:0]                   r_xm;
    frtc_pkg::t_mu                 r_mu;
    logic                          r_mv;
    logic [frtc_pkg::DividendW-1:0] r_sxm;
    logic [15:0]                   r_sm;
    logic [8:0]                    rsum;
    logic                          carry;
    logic                          div_busy;
    logic [frtc_pkg::DividendW-1:0] div_q;
    logic [frtc_pkg::DivisorW-1:0]  div_r;
    logic [frtc_pkg::DividendW-1:0] dvd;
    logic [frtc_pkg::DivisorW-1:0]  dvs;
    logic [24:0]                   prod;

    always_comb begin
        if (r_num == '0) n_eff = frtc_pkg::NumW'(1);
        else if (r_num > frtc_pkg::NumW'(frtc_pkg::MaxSamples))
            n_eff = frtc_pkg::NumW'(frtc_pkg::MaxSamples);
        else n_eff = r_num;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num <= frtc_pkg::NumW'(100);
        end else if (i_cfg_we) begin
            r_num <= i_cfg_wdata;
        end
    end

    // fuzzify and rule pipeline
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_load <= i_in_data[11:0];
            r_dens <= i_in_data[21:12];
            r_det  <= i_in_data[29:22];
        end
        r_mw <= frtc_pkg::fuzz(r_load, frtc_pkg::LwP0, frtc_pkg::LwP1, frtc_pkg::LwP2,
                               frtc_pkg::LwP3, frtc_pkg::K16, frtc_pkg::K48);
        r_mf <= frtc_pkg::fuzz({2'b0, r_dens}, frtc_pkg::FdP0, frtc_pkg::FdP1,
                               frtc_pkg::FdP2, frtc_pkg::FdP3, frtc_pkg::K65, frtc_pkg::K70);
        r_md <= frtc_pkg::fuzz({4'b0, r_det}, frtc_pkg::DaP0, frtc_pkg::DaP1, frtc_pkg::DaP2,
                               frtc_pkg::DaP3, frtc_pkg::K16, frtc_pkg::K16);
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            for (int w = 0; w < 3; w++) begin
                n_part[c][w] = '0;
                for (int f = 0; f < 3; f++) begin
                    for (int d = 0; d < 3; d++) begin
                        if (frtc_pkg::RuleClass[w*9 + f*3 + d] == frtc_pkg::t_cls'(c)) begin
                            n_part[c][w] = frtc_pkg::max2(n_part[c][w],
                                frtc_pkg::min2(r_mw[w], frtc_pkg::min2(r_mf[f], r_md[d])));
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_part <= n_part;
        for (int c = 0; c < 3; c++) begin
            r_cls[c] <= frtc_pkg::max2(r_part[c][0],
                                       frtc_pkg::max2(r_part[c][1], r_part[c][2]));
        end
    end

    // divider, first for the sample step, then for the centroid
    assign dvd = i_cmd.div_final ? r_sxm : frtc_pkg::DividendW'(frtc_pkg::XSpan);
    assign dvs = i_cmd.div_final ? {r_sm, 4'b0} : frtc_pkg::DivisorW'(n_eff);

    frtc_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (dvd),
        .i_divisor   (dvs),
        .o_busy      (div_busy),
        .o_quotient  (div_q),
        .o_remainder (div_r)
    );

    // sample position x_i = i*q + floor(i*r/n)
    assign rsum  = {1'b0, r_xr} + {1'b0, div_r[7:0]};
    assign carry = rsum >= {1'b0, n_eff};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xv <= 1'b0;
            r_mv <= 1'b0;
        end else begin
            r_xv <= i_cmd.advance;
            r_mv <= r_xv;
        end
    end

    assign prod = r_xm * r_mu;

    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_cnt <= '0;
            r_x   <= '0;
            r_xr  <= '0;
            r_sxm <= '0;
            r_sm  <= '0;
        end else begin
            if (i_cmd.advance) begin
                r_cnt <= r_cnt + 1'b1;
                r_x   <= r_x + div_q[15:0] + {15'd0, carry};
                r_xr  <= carry ? 8'(rsum - {1'b0, n_eff}) : rsum[7:0];
            end
            if (r_mv) begin
                r_sxm <= r_sxm + frtc_pkg::DividendW'(prod);
                r_sm  <= r_sm + {7'd0, r_mu};
            end
        end
        r_xm <= r_x;
        r_mu <= frtc_pkg::out_mu(r_x, r_cls);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_no_rule_fired <= r_sm == '0;
            if (r_sm == '0) o_rinse_time <= '0;
            else if (div_q > frtc_pkg::DividendW'(frtc_pkg::RinseMax))
                o_rinse_time <= frtc_pkg::RinseMax;
            else o_rinse_time <= div_q[11:0];
        end
    end

    assign o_st.div_busy    = div_busy;
    assign o_st.last_sample = ({1'b0, r_cnt} + 9'd1) == {1'b0, n_eff};

endmodule

// File: src/frtc_ctrl.sv
module frtc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_valid,
    output logic            o_s_ready,
    output logic            o_m_valid,
    input  logic            i_m_ready,
    output frtc_pkg::t_cmd  o_cmd,
    input  frtc_pkg::t_stat i_st
);

    typedef enum logic [3:0] {
        S_IDLE, S_DIV1S, S_DIV1W, S_INIT, S_STEP,
        S_DRAIN1, S_DRAIN2, S_DIV2S, S_DIV2W, S_OUT
    } t_state;

    t_state r_state;
    logic   r_ovalid;
    logic   load_out;

    assign o_s_ready = r_state == S_IDLE;
    assign o_m_valid = r_ovalid;
    assign load_out  = (r_state == S_OUT) && (!r_ovalid || i_m_ready);

    always_comb begin
        o_cmd           = '0;
        o_cmd.load_in   = o_s_ready && i_s_valid;
        o_cmd.div_start = (r_state == S_DIV1S) || (r_state == S_DIV2S);
        o_cmd.div_final = r_state == S_DIV2S;
        o_cmd.init      = r_state == S_INIT;
        o_cmd.advance   = r_state == S_STEP;
        o_cmd.load_out  = load_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (load_out) r_ovalid <= 1'b1;
            else if (i_m_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE:   if (i_s_valid) r_state <= S_DIV1S;
                S_DIV1S:  r_state <= S_DIV1W;
                S_DIV1W:  if (!i_st.div_busy) r_state <= S_INIT;
                S_INIT:   r_state <= S_STEP;
                S_STEP:   if (i_st.last_sample) r_state <= S_DRAIN1;
                S_DRAIN1: r_state <= S_DRAIN2;
                S_DRAIN2: r_state <= S_DIV2S;
                S_DIV2S:  r_state <= S_DIV2W;
                S_DIV2W:  if (!i_st.div_busy) r_state <= S_OUT;
                S_OUT:    if (load_out) r_state <= S_IDLE;
                default:  r_state <= S_IDLE;
            endcase
        end
    end

    a_div_idle_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |-> !i_st.div_busy)
        else $error("divider started while busy");

    a_div_runs_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_s_ready && i_s_valid) |=> ##1 i_st.div_busy)
        else $error("divider not running after transaction");

    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> o_m_valid)
        else $error("result not presented");

endmodule

// File: src/fuzzy_rinse_time_controller.sv
// fuzzy rinse time controller
// input stream: s_axis_tdata carries load weight, fabric density and detergent
// amount; one transaction per wash cycle. output stream: m_axis_tdata carries
// the crisp rinse time in q4.8, m_axis_tuser flags that no rule fired.
// i_cfg_we with i_cfg_wdata sets the centroid sample count n (0 acts as 1,
// above 128 acts as 128); write it only while the block is idle.
// from an input transaction to result valid the block runs, in order: a
// serial divide (start, 31 shift steps, done check) for the sample step, an
// init state, one centroid sample per cycle, the pipeline drain states
// S_DRAIN1 and S_DRAIN2, a second serial divide for the weighted mean and an
// output load state. one item is processed at a time and the input reopens
// in the cycle after the result is loaded.
// s_axis_tready is high only while the block is idle. the result sits in an
// output register; if the receiver stalls, the next item is still taken and
// processed, and its result waits until the previous one is taken.
// synchronous reset clears the control, drops the output valid and sets n
// back to 100.
module fuzzy_rinse_time_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // load_weight, fabric_density, detergent_amount
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // rinse_time
    output logic [0:0]  m_axis_tuser,  // no_rule_fired
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata
);

    frtc_pkg::t_cmd  cmd;
    frtc_pkg::t_stat st;
    logic [11:0]     rinse;
    logic            flag;

    frtc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_cmd     (cmd),
        .i_st      (st)
    );

    frtc_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_st            (st),
        .i_in_data       (s_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_rinse_time    (rinse),
        .o_no_rule_fired (flag)
    );

    assign m_axis_tdata = {4'b0, rinse};
    assign m_axis_tuser = flag;

endmodule
